@@ design/differential_drive_odometry_unit_macros.svh @@
// Assertion macros for the differential drive odometry unit.
// Needs clk and arst_n in the scope of use.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DDO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DDO_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ design/ddo_pkg.sv @@
// Package for the differential drive odometry unit: payload types, register
// indexes and reset values, angle constants, the arctangent table and saturation helpers. No dependencies.
`default_nettype none
package ddo_pkg;
	typedef struct packed {
		logic signed [15:0] right_wheel_speed;
		logic signed [15:0] left_wheel_speed;
		logic        [15:0] elapsed_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] yaw_rate;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} out_item_t;

	localparam logic [0:0] REG_RADIUS = 1'd0;
	localparam logic [0:0] REG_TRACK  = 1'd1;
	localparam logic [15:0] RADIUS_RST = 16'd3277;
	localparam logic [15:0] TRACK_RST  = 16'd12452;

	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
	localparam int ATAN_ENTRIES = 24;

	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		logic signed [35:0] r;
		case (i)
			5'd0: r = 36'sd843314856;   5'd1: r = 36'sd497837829;
			5'd2: r = 36'sd263043836;   5'd3: r = 36'sd133525158;
			5'd4: r = 36'sd67021686;    5'd5: r = 36'sd33543515;
			5'd6: r = 36'sd16775850;    5'd7: r = 36'sd8388437;
			5'd8: r = 36'sd4194282;     5'd9: r = 36'sd2097149;
			5'd10: r = 36'sd1048575;    5'd11: r = 36'sd524287;
			5'd12: r = 36'sd262143;     5'd13: r = 36'sd131071;
			5'd14: r = 36'sd65535;      5'd15: r = 36'sd32767;
			5'd16: r = 36'sd16383;      5'd17: r = 36'sd8191;
			5'd18: r = 36'sd4095;       5'd19: r = 36'sd2047;
			5'd20: r = 36'sd1023;       5'd21: r = 36'sd511;
			5'd22: r = 36'sd255;        5'd23: r = 36'sd127;
			default: r = 36'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] quat_part(input logic signed [35:0] c);
		logic signed [35:0] q;
		q = (c + 36'sd16384) >>> 15;
		if (q > 36'sd32767) return 16'sh7fff;
		if (q < -36'sd32768) return 16'sh8000;
		return q[15:0];
	endfunction
endpackage
`default_nettype wire

@@ design/differential_drive_odometry_unit.sv @@
// Differential drive odometry unit, top level with sequencer and shared units.
// Depends on ddo_pkg and differential_drive_odometry_unit_macros.svh.
//
// Usage: one update item arrives on in (valid/ready) with both wheel speeds
// and the elapsed time; one result item leaves on out (valid/ready) with the
// pose, velocities, yaw rate and yaw quaternion. Wheel radius and track are
// written on the cfg port (cfg_we, cfg_addr, cfg_data); the user must write
// them only while the block idles, as the block itself does not enforce this.
// Processing: one 33x33 multiply per step, a 40-step restoring divider
// for the yaw rate, two 2*pi reductions and two CORDIC passes of
// min(CORDIC_STEPS, 24) rotations each (one adder set shared). in_ready is
// high only when no item is in work, so the block takes no new item before
// the last one has been written to the output register. A result waits in
// the output register while the receiver stalls; the next item runs up to
// its output step and holds there until that register drains. Reset clears
// the pose to zero, loads the default radius and track and empties the
// output register.
`default_nettype none
`include "differential_drive_odometry_unit_macros.svh"
module differential_drive_odometry_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire ddo_pkg::in_item_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ddo_pkg::out_item_t    out_data,
	input  wire logic             cfg_we,
	input  wire logic             cfg_addr,
	input  wire logic [15:0]      cfg_data
);
	localparam int NSTEP = (CORDIC_STEPS < ddo_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
		: ddo_pkg::ATAN_ENTRIES;

	localparam logic [3:0] S_IDLE = 4'd0, S_VMUL = 4'd1, S_WMUL = 4'd2,
		S_DIV = 4'd3, S_HMUL = 4'd4, S_RED = 4'd5, S_CORD = 4'd6,
		S_VX = 4'd7, S_VY = 4'd8, S_PX = 4'd9, S_PY = 4'd10, S_RED2 = 4'd11,
		S_CORD2 = 4'd12, S_OUT = 4'd13;

	logic [3:0] state_q;
	logic [15:0] radius_q, track_q;
	logic signed [31:0] x_q, y_q, h_q;
	ddo_pkg::in_item_t item_q;
	logic signed [31:0] v_q, w_q, vx_q, vy_q;
	logic signed [35:0] cx_q, cy_q, cz_q;
	logic flip_q;
	logic [5:0] cnt_q;
	// divider: magnitude numerator 40 bits, remainder 17 bits
	logic [39:0] quo_q;
	logic [16:0] rem_q;
	logic neg_q;
	logic num_zero_q;
	logic out_valid_q;
	ddo_pkg::out_item_t out_q;

	// shared multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	assign prod = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_VMUL: begin
				ma = 33'(signed'({1'b0, radius_q}));
				mb = 33'(32'(item_q.right_wheel_speed) + 32'(item_q.left_wheel_speed));
			end
			S_WMUL: begin
				ma = 33'(signed'({1'b0, radius_q}));
				mb = 33'(32'(item_q.right_wheel_speed) - 32'(item_q.left_wheel_speed));
			end
			S_HMUL: begin
				ma = 33'(w_q);
				mb = 33'(signed'({1'b0, item_q.elapsed_time}));
			end
			S_VX: begin ma = 33'(v_q); mb = 33'(flip_q ? -cx_q : cx_q); end
			S_VY: begin ma = 33'(v_q); mb = 33'(flip_q ? -cy_q : cy_q); end
			S_PX: begin ma = 33'(vx_q); mb = 33'(signed'({1'b0, item_q.elapsed_time})); end
			S_PY: begin ma = 33'(vy_q); mb = 33'(signed'({1'b0, item_q.elapsed_time})); end
			default: ;
		endcase
	end

	// CORDIC step and angle reduction
	logic signed [35:0] shx, shy, at;
	logic [4:0] ci;
	logic signed [47:0] red_z;
	assign ci = cnt_q[4:0];
	assign shx = cx_q >>> ci;
	assign shy = cy_q >>> ci;
	assign at = ddo_pkg::atan_q30(ci);
	// heading in Q.30: up to 2^45 in magnitude
	assign red_z = (state_q == S_RED) ? 48'(h_q) <<< 14 : 48'(h_q) <<< 13;

	// modulo by 2*pi: a multiple subtract loop, one compare/subtract per cycle
	logic signed [47:0] md_q;
	logic [4:0] mk_q;
	logic mdone_q;
	logic signed [47:0] tp_sh;
	assign tp_sh = 48'(ddo_pkg::TWO_PI_Q30) <<< mk_q;

	logic [16:0] dtrial;
	assign dtrial = {rem_q[15:0], quo_q[39]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			radius_q <= ddo_pkg::RADIUS_RST;
			track_q <= ddo_pkg::TRACK_RST;
			x_q <= '0;
			y_q <= '0;
			h_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			mk_q <= '0;
			mdone_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == ddo_pkg::REG_RADIUS) radius_q <= cfg_data;
				else track_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					item_q <= in_data;
					state_q <= S_VMUL;
				end
				S_VMUL: begin
					v_q <= 32'((prod + 66'sd256) >>> 9);
					state_q <= S_WMUL;
				end
				S_WMUL: begin
					// |num| = |r*(wR-wL)| < 2^32, times 256 -> 40 bits
					neg_q <= prod[65];
					num_zero_q <= (prod == '0);
					quo_q <= {(prod[65] ? 32'(-prod) : prod[31:0]), 8'd0};
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dtrial >= {1'b0, track_q}) begin
						rem_q <= dtrial - {1'b0, track_q};
						quo_q <= {quo_q[38:0], 1'b1};
					end else begin
						rem_q <= dtrial;
						quo_q <= {quo_q[38:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd39) state_q <= S_HMUL;
				end
				S_HMUL: begin
					// w_q was loaded at the last divide step
					h_q <= ddo_pkg::sat32(64'(h_q) + 64'((prod + 66'sd32768) >>> 16));
					md_q <= '0;
					mk_q <= 5'd12;
					mdone_q <= 1'b0;
					state_q <= S_RED;
				end
				S_RED, S_RED2: begin
					if (!mdone_q) begin
						if (md_q == '0 && mk_q == 5'd12) md_q <= red_z;
						else begin
							logic signed [47:0] m;
							m = md_q;
							if (m >= 0 && m >= tp_sh) m = m - tp_sh;
							else if (m < 0 && -m >= tp_sh) m = m + tp_sh;
							md_q <= m;
							if (mk_q == 5'd0) mdone_q <= 1'b1;
							else mk_q <= mk_q - 5'd1;
						end
						if (red_z == 0) mdone_q <= 1'b1;
					end else begin
						logic signed [47:0] z;
						logic f;
						z = md_q;
						f = 1'b0;
						if (z >= 48'(ddo_pkg::PI_Q30)) z = z - 48'(ddo_pkg::TWO_PI_Q30);
						if (z < -48'(ddo_pkg::PI_Q30)) z = z + 48'(ddo_pkg::TWO_PI_Q30);
						if (z > 48'(ddo_pkg::HALF_PI_Q30)) begin
							z = z - 48'(ddo_pkg::PI_Q30); f = 1'b1;
						end else if (z < -48'(ddo_pkg::HALF_PI_Q30)) begin
							z = z + 48'(ddo_pkg::PI_Q30); f = 1'b1;
						end
						cz_q <= 36'(z);
						flip_q <= f;
						cx_q <= ddo_pkg::GAIN_Q30;
						cy_q <= '0;
						cnt_q <= '0;
						state_q <= (state_q == S_RED) ? S_CORD : S_CORD2;
					end
				end
				S_CORD, S_CORD2: begin
					if (cz_q >= 0) begin
						cx_q <= cx_q - shy; cy_q <= cy_q + shx; cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + shy; cy_q <= cy_q - shx; cz_q <= cz_q + at;
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(NSTEP - 1)) begin
						state_q <= (state_q == S_CORD) ? S_VX : S_OUT;
					end
				end
				S_VX: begin
					vx_q <= ddo_pkg::sat32(64'((prod + 66'sd536870912) >>> 30));
					state_q <= S_VY;
				end
				S_VY: begin
					vy_q <= ddo_pkg::sat32(64'((prod + 66'sd536870912) >>> 30));
					state_q <= S_PX;
				end
				S_PX: begin
					x_q <= ddo_pkg::sat32(64'(x_q) + 64'((prod + 66'sd32768) >>> 16));
					state_q <= S_PY;
				end
				S_PY: begin
					y_q <= ddo_pkg::sat32(64'(y_q) + 64'((prod + 66'sd32768) >>> 16));
					md_q <= '0;
					mk_q <= 5'd12;
					mdone_q <= 1'b0;
					state_q <= S_RED2;
				end
				S_OUT: if (!out_valid_q || out_ready) begin
					out_q.pos_x <= x_q;
					out_q.pos_y <= y_q;
					out_q.heading <= h_q;
					out_q.vel_x <= vx_q;
					out_q.vel_y <= vy_q;
					out_q.yaw_rate <= w_q;
					out_q.quat_z <= ddo_pkg::quat_part(flip_q ? -cy_q : cy_q);
					out_q.quat_w <= ddo_pkg::quat_part(flip_q ? -cx_q : cx_q);
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// yaw rate from divider result (valid from S_HMUL on)
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && cnt_q == 6'd39) begin
			logic [39:0] qn;
			logic signed [40:0] qs;
			qn = {quo_q[38:0], (dtrial >= {1'b0, track_q})};
			qs = neg_q ? -41'(qn) : 41'(qn);
			if (track_q == '0) begin
				w_q <= num_zero_q ? 32'sd0 : (neg_q ? 32'sh80000000 : 32'sh7fffffff);
			end else begin
				w_q <= ddo_pkg::sat32(64'(qs));
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`DDO_ASSERT(a_busy_not_ready, (state_q != S_IDLE) |-> !in_ready, "ready while busy")
	`DDO_ASSERT(a_start, (in_valid && in_ready) |=> (state_q == S_VMUL), "accept lost")
	`DDO_ASSERT(a_out_hold, (out_valid && !out_ready) |=> $stable(out_data), "result moved")
	`DDO_ASSERT_RST(a_rst, !arst_n |-> !out_valid, "valid in reset")
endmodule
`default_nettype wire

@@ dv/differential_drive_odometry_unit_test.sv @@
// Self-checking testbench for differential_drive_odometry_unit: random and directed
// odometry updates, an in-house fixed-point pose predictor and a result scoreboard.
// Depends on ddo_pkg and the RTL of the block.
`default_nettype none
module differential_drive_odometry_unit_test;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ddo_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	ddo_pkg::out_item_t out_data;
	logic cfg_we;
	logic cfg_addr;
	logic [15:0] cfg_data;

	differential_drive_odometry_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] radius_q;
	logic [15:0] track_q;
	logic signed [31:0] px_q, py_q, hd_q;

	ddo_pkg::in_item_t update_q[$];
	ddo_pkg::out_item_t pose_q[$];
	int errors = 0;
	bit quiet_tail = 0;
	bit hold_rx = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint floor_sh(longint x, int s);
		return x >>> s;
	endfunction

	function automatic longint round_sh(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic logic signed [15:0] half_q15(longint v);
		longint q;
		q = round_sh(v, 15);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	// rotation-mode CORDIC, Q.30 angle in, Q.30 cos/sin out
	task automatic rotate_q30(input longint ang, output longint c, output longint s);
		longint x, y, z, nx;
		longint atans[24];
		bit flip;
		atans = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
			65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
		x = 652032874; y = 0; flip = 0;
		z = ang % 64'sd6746518852;
		if (z >= 64'sd3373259426) z -= 64'sd6746518852;
		if (z < -64'sd3373259426) z += 64'sd6746518852;
		if (z > 64'sd1686629713) begin
			z -= 64'sd3373259426; flip = 1;
		end else if (z < -64'sd1686629713) begin
			z += 64'sd3373259426; flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - floor_sh(y, i); y = y + floor_sh(x, i); z -= atans[i];
			end else begin
				nx = x + floor_sh(y, i); y = y - floor_sh(x, i); z += atans[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_pose(input ddo_pkg::in_item_t it);
		longint wr, wl, dt, r, v, num, wq, w, c, s, vx, vy, hc, hs;
		ddo_pkg::out_item_t o;
		wr = it.right_wheel_speed;
		wl = it.left_wheel_speed;
		dt = it.elapsed_time;
		r = radius_q;
		v = round_sh(r * (wr + wl), 9);
		num = r * (wr - wl) * 256;
		if (track_q == 0)
			wq = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
		else
			wq = num / longint'(track_q);
		w = clip32(wq);
		hd_q = 32'(clip32(longint'(hd_q) + round_sh(w * dt, 16)));
		rotate_q30(longint'(hd_q) * 16384, c, s);
		vx = round_sh(v * c, 30);
		vy = round_sh(v * s, 30);
		px_q = 32'(clip32(longint'(px_q) + round_sh(vx * dt, 16)));
		py_q = 32'(clip32(longint'(py_q) + round_sh(vy * dt, 16)));
		rotate_q30(longint'(hd_q) * 8192, hc, hs);
		o.pos_x = px_q; o.pos_y = py_q; o.heading = hd_q;
		o.vel_x = 32'(clip32(vx)); o.vel_y = 32'(clip32(vy)); o.yaw_rate = 32'(w);
		o.quat_z = half_q15(hs); o.quat_w = half_q15(hc);
		pose_q.push_back(o);
	endtask

	// sender: pending updates go out with random gaps
	int tx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_pose(in_data);
				if (!quiet_tail && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 12);
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 0;
				end else if (update_q.size() > 0) begin
					in_valid <= 1;
					in_data <= update_q.pop_front();
				end else
					in_valid <= 0;
			end
		end
	end

	// receiver with random stalls and a long hold-off when requested
	int rx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			rx_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					$error("result transfer with no pending expectation");
					errors++;
				end else begin
					ddo_pkg::out_item_t e;
					e = pose_q.pop_front();
					if (e.pos_x !== out_data.pos_x) begin
						$error("pos_x exp %0d got %0d", e.pos_x, out_data.pos_x); errors++;
					end
					if (e.pos_y !== out_data.pos_y) begin
						$error("pos_y exp %0d got %0d", e.pos_y, out_data.pos_y); errors++;
					end
					if (e.heading !== out_data.heading) begin
						$error("heading exp %0d got %0d", e.heading, out_data.heading);
						errors++;
					end
					if (e.vel_x !== out_data.vel_x) begin
						$error("vel_x exp %0d got %0d", e.vel_x, out_data.vel_x); errors++;
					end
					if (e.vel_y !== out_data.vel_y) begin
						$error("vel_y exp %0d got %0d", e.vel_y, out_data.vel_y); errors++;
					end
					if (e.yaw_rate !== out_data.yaw_rate) begin
						$error("yaw_rate exp %0d got %0d", e.yaw_rate, out_data.yaw_rate);
						errors++;
					end
					if (e.quat_z !== out_data.quat_z) begin
						$error("quat_z exp %0d got %0d", e.quat_z, out_data.quat_z); errors++;
					end
					if (e.quat_w !== out_data.quat_w) begin
						$error("quat_w exp %0d got %0d", e.quat_w, out_data.quat_w); errors++;
					end
				end
			end
			if (hold_rx)
				out_ready <= 0;
			else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 0;
			end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				rx_gap = $urandom_range(1, 12) - 1;
				out_ready <= 0;
			end else
				out_ready <= 1;
		end
	end

	task automatic add_update(logic [15:0] wr, logic [15:0] wl, logic [15:0] dt);
		ddo_pkg::in_item_t it;
		it.right_wheel_speed = wr;
		it.left_wheel_speed = wl;
		it.elapsed_time = dt;
		update_q.push_back(it);
	endtask

	task automatic drain_all();
		while (update_q.size() > 0 || in_valid || pose_q.size() > 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// config write while idle; predictor follows immediately
	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == ddo_pkg::REG_RADIUS) radius_q = val; else track_q = val;
		@(posedge clk);
	endtask

	task automatic random_burst(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 4))
				0: add_update(16'($urandom), 16'($urandom), 16'($urandom));
				1: add_update(16'($urandom_range(0, 2560)), 16'($urandom_range(0, 2560)),
					16'($urandom_range(0, 20000)));
				2: begin
					logic [15:0] a;
					a = 16'($urandom_range(0, 4000)) - 16'd2000;
					add_update(a, a + 16'($urandom_range(0, 64)) - 16'd32,
						16'($urandom_range(0, 13107)));
				end
				3: add_update(16'($urandom), 16'd0 - 16'($urandom_range(0, 3000)),
					16'($urandom_range(60000, 65535)));
				default: add_update(16'($urandom_range(0, 1500)) - 16'd750,
					16'($urandom_range(0, 1500)) - 16'd750, 16'($urandom_range(0, 65535)));
			endcase
		end
	endtask

	initial begin
		cfg_we = 0; cfg_addr = ddo_pkg::REG_RADIUS; cfg_data = 0;
		radius_q = ddo_pkg::RADIUS_RST; track_q = ddo_pkg::TRACK_RST;
		px_q = 0; py_q = 0; hd_q = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes at reset geometry
		add_update(16'd0, 16'd0, 16'd0);
		add_update(16'h7fff, 16'h7fff, 16'hffff);
		add_update(16'h8000, 16'h8000, 16'hffff);
		add_update(16'h7fff, 16'h8000, 16'hffff);
		add_update(16'h8000, 16'h7fff, 16'hffff);
		add_update(16'd256, 16'd256, 16'd13107);
		add_update(16'd256, 16'hff00, 16'd13107);
		add_update(16'd0, 16'd0, 16'hffff);
		drain_all();

		// zero track, then heading saturation with a small track
		write_reg(ddo_pkg::REG_TRACK, 16'd0);
		add_update(16'h7fff, 16'h8000, 16'hffff);
		add_update(16'h8000, 16'h7fff, 16'hffff);
		add_update(16'd100, 16'd100, 16'd1000);
		add_update(16'd77, 16'd77, 16'd1000);
		drain_all();
		write_reg(ddo_pkg::REG_RADIUS, 16'hffff);
		write_reg(ddo_pkg::REG_TRACK, 16'd1);
		for (int i = 0; i < 6; i++) add_update(16'h7fff, 16'h8000, 16'hffff);
		for (int i = 0; i < 6; i++) add_update(16'h8000, 16'h7fff, 16'hffff);
		drain_all();

		// zero radius holds the pose
		write_reg(ddo_pkg::REG_RADIUS, 16'd0);
		add_update(16'h7fff, 16'h1234, 16'hffff);
		add_update(16'h8000, 16'h8000, 16'hffff);
		drain_all();

		// long receiver hold-off while the sender keeps offering
		write_reg(ddo_pkg::REG_RADIUS, ddo_pkg::RADIUS_RST);
		write_reg(ddo_pkg::REG_TRACK, 16'hffff);
		hold_rx = 1;
		random_burst(10);
		repeat (600) @(posedge clk);
		hold_rx = 0;
		drain_all();

		// random phases across several geometries; position saturation rides along
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(ddo_pkg::REG_RADIUS, ph == 0 ? 16'hffff : ph == 1 ? 16'd1 :
				16'($urandom_range(1, 65535)));
			write_reg(ddo_pkg::REG_TRACK, ph == 2 ? 16'd1 : ph == 3 ? 16'hffff :
				16'($urandom_range(1, 65535)));
			if (ph == 5) quiet_tail = 1;
			random_burst(200);
			drain_all();
		end

		if (errors == 0)
			$display("differential_drive_odometry_unit_test passed");
		else
			$display("differential_drive_odometry_unit_test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("differential_drive_odometry_unit_test failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+design
design/ddo_pkg.sv
design/differential_drive_odometry_unit.sv
dv/differential_drive_odometry_unit_test.sv
